/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the command queue modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clk edge outside reset.
`define CCQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ccq assertion failed");

// Checked on every clk edge, reset included.
`define CCQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ccq assertion failed");

`endif

/* src/ccq_pkg.sv */
// ---------------------------------------------------------------------------
// ccq_pkg
// Types and constants of the coalescing command queue.
// ---------------------------------------------------------------------------
package ccq_pkg;

  localparam int QUEUE_DEPTH_DEF = 10;

  localparam logic [7:0] ACK_OP        = 8'h09;
  localparam logic [7:0] ADDR_POLL_OP  = 8'h01;
  localparam logic [7:0] COUNT_POLL_OP = 8'h04;
  localparam logic [2:0] ACK_LEN        = 3'd2;
  localparam logic [2:0] ADDR_POLL_LEN  = 3'd2;
  localparam logic [2:0] COUNT_POLL_LEN = 3'd1;
  localparam logic [3:0] RETRY_SAT      = 4'd15;

  localparam logic [7:0] RETRY_TICKS_RST  = 8'd5;
  localparam logic [3:0] MAX_RETRIES_RST  = 4'd4;
  localparam logic [7:0] ADDR_PERIOD_RST  = 8'd200;
  localparam logic [7:0] COUNT_PERIOD_RST = 8'd100;

  localparam int NUM_JOBS = 5;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_ENQ  = 2'd1,
    REQ_RESP = 2'd2,
    REQ_ACK  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_RETRY_TICKS  = 2'd0,
    CFG_MAX_RETRIES  = 2'd1,
    CFG_ADDR_PERIOD  = 2'd2,
    CFG_COUNT_PERIOD = 2'd3
  } cfg_idx_t;

  // Pending enqueue jobs, bit position in the controller's job mask.
  typedef enum logic [2:0] {
    JOB_ITEM  = 3'd0,
    JOB_ADDR0 = 3'd1,
    JOB_ADDR1 = 3'd2,
    JOB_CNT0  = 3'd3,
    JOB_CNT1  = 3'd4
  } job_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic       side;
    logic [2:0] len;
    logic [7:0] a3;
    logic [7:0] a2;
    logic [7:0] a1;
    logic [7:0] op;
  } entry_t;

  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       load_job;
    job_sel_t   job_sel;
    logic       scan_step;
  } ctrl_cmd_t;

  typedef struct packed {
    req_t req;
    logic out_busy;
    logic fire_addr;
    logic fire_count;
  } dp_status_t;

endpackage

/* src/coalescing_command_queue_retry.sv */
// ---------------------------------------------------------------------------
// coalescing_command_queue_retry
// Coalescing outgoing command queue with retry timer and periodic polls.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in      | in  | in_tvalid/tready   | tuser req_type, tdata command+status
//  out     | out | out_tvalid/tready  | tuser msg_kind, tdata message
//  cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
//
//  An ack or response beat is accepted and executed; an enqueue beat also
//  rotates the queue once through the slot compare at the head; a tick
//  does so once per fired poll command, up to 4 of them.
//  Reset clears the queue and all control state at once, no clearing pass.
//  A finished beat waits in the output register while the next input beat
//  is taken; any tick or response stalls until that register drains, an
//  enqueue or ack runs regardless.
//  cfg is always ready.
// ---------------------------------------------------------------------------
module coalescing_command_queue_retry
  import ccq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // req_type
  input  logic [47:0] in_tdata,   // opcode, arg_one, arg_two, arg_three,
                                  // send_len, side, resp_status, zero pad
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // msg_kind
  output logic [39:0] out_tdata,  // out_opcode, out_arg_one, out_arg_two,
                                  // out_arg_three, out_len, out_side, zero pad
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // registers are plain flops, a write never stalls
  assign cfg_ready = 1'b1;

  // controller: accept, execute, and one queue rotation per pending enqueue
  ccq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: queue shift line, timer, poll counters, output register
  ccq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

/* src/ccq_ctrl.sv */
// ---------------------------------------------------------------------------
// ccq_ctrl
// Sequencer: accept, execute, then one rotation pass per pending enqueue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccq_ctrl
  import ccq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam int CW = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] LAST = CW'(QUEUE_DEPTH - 1);

  state_t              state_r, state_nxt;
  logic [NUM_JOBS-1:0] mask_r, mask_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mask_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    logic picked;
    picked    = 1'b0;
    state_nxt = state_r;
    mask_nxt  = mask_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '{capture: 1'b0, exec: 1'b0, load_job: 1'b0,
                  job_sel: JOB_ITEM, scan_step: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // tick and response may load the output register
        if (!status.out_busy || status.req == REQ_ENQ || status.req == REQ_ACK) begin
          cmd.exec = 1'b1;
          mask_nxt = '0;
          if (status.req == REQ_ENQ) begin
            mask_nxt[JOB_ITEM] = 1'b1;
          end
          if (status.req == REQ_TICK) begin
            mask_nxt[JOB_ADDR0] = status.fire_addr;
            mask_nxt[JOB_ADDR1] = status.fire_addr;
            mask_nxt[JOB_CNT0]  = status.fire_count;
            mask_nxt[JOB_CNT1]  = status.fire_count;
          end
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (mask_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          for (int i = 0; i < NUM_JOBS; i++) begin
            if (mask_r[i] && !picked) begin
              picked      = 1'b1;
              cmd.job_sel = job_sel_t'(3'(i));
              mask_nxt[i] = 1'b0;
            end
          end
          cmd.load_job = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_LOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `CCQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == ST_IDLE)
  `CCQ_ASSERT(a_idle_no_jobs, state_r == ST_IDLE |-> mask_r == '0)
  `CCQ_ASSERT(a_accept_exec, in_tvalid && in_tready |=> state_r == ST_EXEC)

endmodule

/* src/ccq_datapath.sv */
// ---------------------------------------------------------------------------
// ccq_datapath
// Queue shift line, retry timer, poll counters, config and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccq_datapath
  import ccq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0]  in_tuser,
  input  logic [47:0] in_tdata,
  input  logic       cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic       out_tuser,
  output logic [39:0] out_tdata
);

  // captured item
  req_t       req_r, req_nxt;
  entry_t     ient_r, ient_nxt;
  logic [7:0] rstat_r, rstat_nxt;

  entry_t q_r   [QUEUE_DEPTH];
  entry_t q_nxt [QUEUE_DEPTH];

  logic       so_r, so_nxt;
  logic       tr_r, tr_nxt;
  logic [7:0] wc_r, wc_nxt;
  logic [3:0] rc_r, rc_nxt;
  logic [7:0] ac_r, ac_nxt;
  logic [7:0] cc_r, cc_nxt;

  logic [7:0] retry_ticks_r;
  logic [3:0] max_retries_r;
  logic [7:0] addr_period_r;
  logic [7:0] count_period_r;

  entry_t job_r, job_nxt;
  logic   found_r, found_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_kind_r, out_kind_nxt;
  entry_t out_ent_r, out_ent_nxt;

  logic [7:0] ac_dec, cc_dec;
  logic       exec_tick;

  assign ac_dec    = (ac_r != 8'd0) ? ac_r - 8'd1 : ac_r;
  assign cc_dec    = (cc_r != 8'd0) ? cc_r - 8'd1 : cc_r;
  assign exec_tick = cmd.exec && (req_r == REQ_TICK);

  assign status = '{req: req_r, out_busy: out_valid_r && !out_tready,
                    fire_addr: ac_dec == 8'd0, fire_count: cc_dec == 8'd0};

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'b0000, out_ent_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_ticks_r  <= RETRY_TICKS_RST;
      max_retries_r  <= MAX_RETRIES_RST;
      addr_period_r  <= ADDR_PERIOD_RST;
      count_period_r <= COUNT_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RETRY_TICKS:  retry_ticks_r  <= cfg_data;
        CFG_MAX_RETRIES:  max_retries_r  <= cfg_data[3:0];
        CFG_ADDR_PERIOD:  addr_period_r  <= cfg_data;
        CFG_COUNT_PERIOD: count_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        q_r[k] <= '0;
      end
      so_r        <= 1'b0;
      tr_r        <= 1'b0;
      wc_r        <= '0;
      rc_r        <= '0;
      ac_r        <= '0;
      cc_r        <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        q_r[k] <= q_nxt[k];
      end
      so_r        <= so_nxt;
      tr_r        <= tr_nxt;
      wc_r        <= wc_nxt;
      rc_r        <= rc_nxt;
      ac_r        <= ac_nxt;
      cc_r        <= cc_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ient_r     <= ient_nxt;
    rstat_r    <= rstat_nxt;
    job_r      <= job_nxt;
    out_kind_r <= out_kind_nxt;
    out_ent_r  <= out_ent_nxt;
  end

  always_comb begin
    logic       send;
    logic       so1;
    logic       tr1;
    logic [7:0] wc1;
    logic [3:0] rc1;
    logic       hit;
    send = 1'b0;
    so1  = so_r;
    tr1  = tr_r;
    wc1  = wc_r;
    rc1  = rc_r;
    hit  = 1'b0;

    req_nxt       = req_r;
    ient_nxt      = ient_r;
    rstat_nxt     = rstat_r;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      q_nxt[k] = q_r[k];
    end
    so_nxt        = so_r;
    tr_nxt        = tr_r;
    wc_nxt        = wc_r;
    rc_nxt        = rc_r;
    ac_nxt        = ac_r;
    cc_nxt        = cc_r;
    job_nxt       = job_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_ent_nxt   = out_ent_r;

    if (cmd.capture) begin
      req_nxt   = req_t'(in_tuser);
      ient_nxt  = entry_t'(in_tdata[35:0]);
      rstat_nxt = in_tdata[43:36];
    end

    if (cmd.exec) begin
      unique case (req_r)
        REQ_TICK: begin
          send = !so_r && (q_r[0].op != 8'd0);
          if (send) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = 1'b0;
            out_ent_nxt   = q_r[0];
            so1 = 1'b1;
            wc1 = retry_ticks_r;
            tr1 = 1'b1;
          end
          if (tr1) begin
            if (wc1 != 8'd0) begin
              wc1 = wc1 - 8'd1;
            end
            if (wc1 == 8'd0) begin
              so1 = 1'b0;
              if (rc1 != RETRY_SAT) begin
                rc1 = rc1 + 4'd1;
              end
            end
          end
          // too many retries: drop the head
          if (rc1 > max_retries_r) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
              q_nxt[k] = q_r[k+1];
            end
            q_nxt[QUEUE_DEPTH-1] = '0;
            so1 = 1'b0;
            rc1 = '0;
            tr1 = 1'b0;
          end
          so_nxt = so1;
          tr_nxt = tr1;
          wc_nxt = wc1;
          rc_nxt = rc1;
          ac_nxt = (ac_dec == 8'd0) ? addr_period_r : ac_dec;
          cc_nxt = (cc_dec == 8'd0) ? count_period_r : cc_dec;
        end
        REQ_RESP: begin
          tr_nxt = 1'b0;
          if (rstat_r != ACK_OP) begin
            if (rstat_r != 8'd0) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = 1'b1;
              out_ent_nxt   = '{side: q_r[0].side, len: ACK_LEN, a3: 8'd0,
                                a2: 8'd0, a1: rstat_r, op: ACK_OP};
            end
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
              q_nxt[k] = q_r[k+1];
            end
            q_nxt[QUEUE_DEPTH-1] = '0;
            so_nxt = 1'b0;
          end
        end
        REQ_ACK: tr_nxt = 1'b0;
        default: ;
      endcase
    end

    if (cmd.load_job) begin
      found_nxt = 1'b0;
      case (cmd.job_sel)
        JOB_ADDR0: job_nxt = '{side: 1'b0, len: ADDR_POLL_LEN, a3: 8'd0, a2: 8'd0,
                               a1: 8'd0, op: ADDR_POLL_OP};
        JOB_ADDR1: job_nxt = '{side: 1'b1, len: ADDR_POLL_LEN, a3: 8'd0, a2: 8'd0,
                               a1: 8'd0, op: ADDR_POLL_OP};
        JOB_CNT0:  job_nxt = '{side: 1'b0, len: COUNT_POLL_LEN, a3: 8'd0, a2: 8'd0,
                               a1: 8'd0, op: COUNT_POLL_OP};
        JOB_CNT1:  job_nxt = '{side: 1'b1, len: COUNT_POLL_LEN, a3: 8'd0, a2: 8'd0,
                               a1: 8'd0, op: COUNT_POLL_OP};
        default:   job_nxt = ient_r;
      endcase
    end

    // one full rotation; the first empty or same-key slot passing the head takes the job
    if (cmd.scan_step) begin
      hit = !found_r && ((q_r[0].op == 8'd0) ||
                         (q_r[0].op == job_r.op && q_r[0].side == job_r.side));
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        q_nxt[k] = q_r[k+1];
      end
      q_nxt[QUEUE_DEPTH-1] = hit ? job_r : q_r[0];
      if (hit) begin
        found_nxt = 1'b1;
      end
    end
  end

  `CCQ_ASSERT(a_retry_bound, exec_tick |=> rc_r <= $past(max_retries_r))

endmodule

/* tb/coalescing_command_queue_retry_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coalescing_command_queue_retry_tb
// Self-checking bench for the coalescing command queue: a scoreboard class
// tracks queue contents, the retry timer and the poll counters, predicts
// every message beat, and checks each beat leaving the block in order.
// ---------------------------------------------------------------------------
module coalescing_command_queue_retry_tb;
  import ccq_pkg::*;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int HOLD_OFF   = 80;     // covers the worst tick plus output wait
  localparam int QUIET_MAX  = 4000;   // cycles with no beat anywhere
  localparam int RAND_ITEMS = 205;    // per random phase, five phases

  typedef struct packed {
    logic   kind;
    entry_t body;
  } msg_t;

  // -------------------------------------------------------------------------
  // Scoreboard: shadow of the queue and its control state.
  // -------------------------------------------------------------------------
  class link_queue_scoreboard;
    entry_t     slots[DEPTH];
    bit         send_busy;
    bit         timer_on;
    logic [7:0] wait_cnt;
    logic [3:0] retries;
    logic [7:0] addr_cnt;
    logic [7:0] count_cnt;
    logic [7:0] retry_ticks;
    logic [3:0] max_retries;
    logic [7:0] addr_period;
    logic [7:0] count_period;
    msg_t       msg_expected[$];
    int         mismatches;

    function new();
      foreach (slots[k]) slots[k] = '0;
      send_busy    = 1'b0;
      timer_on     = 1'b0;
      wait_cnt     = '0;
      retries      = '0;
      addr_cnt     = '0;
      count_cnt    = '0;
      retry_ticks  = RETRY_TICKS_RST;
      max_retries  = MAX_RETRIES_RST;
      addr_period  = ADDR_PERIOD_RST;
      count_period = COUNT_PERIOD_RST;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [7:0] val);
      case (idx)
        CFG_RETRY_TICKS:  retry_ticks  = val;
        CFG_MAX_RETRIES:  max_retries  = val[3:0];
        CFG_ADDR_PERIOD:  addr_period  = val;
        CFG_COUNT_PERIOD: count_period = val;
        default: ;
      endcase
    endfunction

    // First empty slot or same opcode+side wins; nothing found means lost.
    function void place(entry_t e);
      for (int k = 0; k < DEPTH; k++) begin
        if (slots[k].op == 8'h00 || (slots[k].op == e.op && slots[k].side == e.side)) begin
          slots[k] = e;
          return;
        end
      end
    endfunction

    function void pop_head();
      for (int k = 0; k + 1 < DEPTH; k++) slots[k] = slots[k + 1];
      slots[DEPTH - 1] = '0;
    endfunction

    function void place_poll(logic [7:0] op, logic [2:0] len);
      entry_t e;
      e = '0;
      e.op  = op;
      e.len = len;
      place(e);
      e.side = 1'b1;
      place(e);
    endfunction

    function void take_beat(req_t req, entry_t cmd, logic [7:0] status);
      msg_t m;
      m = '0;
      case (req)
        REQ_TICK: begin
          if (!send_busy && slots[0].op != 8'h00) begin
            m.kind = 1'b0;
            m.body = slots[0];
            msg_expected.push_back(m);
            send_busy = 1'b1;
            wait_cnt  = retry_ticks;
            timer_on  = 1'b1;
          end
          if (timer_on) begin
            if (wait_cnt != 8'd0) wait_cnt = wait_cnt - 8'd1;
            if (wait_cnt == 8'd0) begin
              send_busy = 1'b0;
              if (retries != RETRY_SAT) retries = retries + 4'd1;
            end
          end
          if (retries > max_retries) begin
            pop_head();
            send_busy = 1'b0;
            retries   = '0;
            timer_on  = 1'b0;
          end
          if (addr_cnt != 8'd0) addr_cnt = addr_cnt - 8'd1;
          if (addr_cnt == 8'd0) begin
            place_poll(ADDR_POLL_OP, ADDR_POLL_LEN);
            addr_cnt = addr_period;
          end
          if (count_cnt != 8'd0) count_cnt = count_cnt - 8'd1;
          if (count_cnt == 8'd0) begin
            place_poll(COUNT_POLL_OP, COUNT_POLL_LEN);
            count_cnt = count_period;
          end
        end
        REQ_ENQ: place(cmd);
        REQ_RESP: begin
          // status equal to the ack opcode only stops the timer
          if (status != ACK_OP) begin
            if (status != 8'h00) begin
              m.kind      = 1'b1;
              m.body.op   = ACK_OP;
              m.body.a1   = status;
              m.body.len  = ACK_LEN;
              m.body.side = slots[0].side;
              msg_expected.push_back(m);
            end
            pop_head();
            send_busy = 1'b0;
          end
          timer_on = 1'b0;
        end
        default: timer_on = 1'b0;
      endcase
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
    endfunction

    function void check_message(logic kind, entry_t got);
      msg_t want;
      if (msg_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected message: kind %b data %h", $realtime, kind, got);
        return;
      end
      want = msg_expected.pop_front();
      cmp_field("msg_kind",      {7'b0, want.kind},      {7'b0, kind});
      cmp_field("out_opcode",    want.body.op,           got.op);
      cmp_field("out_arg_one",   want.body.a1,           got.a1);
      cmp_field("out_arg_two",   want.body.a2,           got.a2);
      cmp_field("out_arg_three", want.body.a3,           got.a3);
      cmp_field("out_len",       {5'b0, want.body.len},  {5'b0, got.len});
      cmp_field("out_side",      {7'b0, want.body.side}, {7'b0, got.side});
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT hookup
  // -------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;   // req_type
  logic [47:0] in_tdata = '0;   // opcode, args, send_len, side, resp_status, pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tuser;       // msg_kind
  logic [39:0] out_tdata;       // opcode, args, len, side, pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  link_queue_scoreboard link_book = new();

  int quiet_cycles = 0;
  int burst_left   = 0;
  int stall_left   = 0;
  int stall_mode   = 0;

  always #2 clk = ~clk;

  coalescing_command_queue_retry #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Receiver: modes change at random intervals - always ready,
  // coin flip, or mostly stalled.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Every message beat leaving the block is checked against the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      link_book.check_message(out_tuser, entry_t'(out_tdata[35:0]));
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("coalescing_command_queue_retry_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  // One input beat; then maybe close the burst with a gap.
  task automatic push_beat(req_t req, entry_t cmd, logic [7:0] status);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, status, cmd};
    do @(posedge clk); while (!in_tready);
    link_book.take_beat(req, cmd, status);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic enq_beat(logic [7:0] op, logic [7:0] a1, logic [7:0] a2, logic [7:0] a3,
                          logic [2:0] len, logic side);
    push_beat(REQ_ENQ, {side, len, a3, a2, a1, op}, 8'h00);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    link_book.write_reg(idx, val);
  endtask

  // Idle the sender, wait for all messages, then let enqueues finish inside.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (link_book.msg_expected.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Random traffic: weights in percent for tick, enqueue, response; ack the rest.
  task automatic random_run(int n, int w_tick, int w_enq, int w_resp);
    entry_t     cmd;
    logic [7:0] status;
    req_t       req;
    int         r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_tick)                       req = REQ_TICK;
      else if (r < w_tick + w_enq)          req = REQ_ENQ;
      else if (r < w_tick + w_enq + w_resp) req = REQ_RESP;
      else                                  req = REQ_ACK;
      // opcodes lean toward poll opcodes and a small set so coalescing happens
      r = $urandom_range(0, 99);
      if (r < 10)      cmd.op = 8'h00;
      else if (r < 20) cmd.op = ADDR_POLL_OP;
      else if (r < 30) cmd.op = COUNT_POLL_OP;
      else if (r < 35) cmd.op = ACK_OP;
      else if (r < 55) cmd.op = 8'h20 + 8'($urandom_range(0, 5));
      else             cmd.op = 8'($urandom);
      cmd.a1   = 8'($urandom);
      cmd.a2   = 8'($urandom);
      cmd.a3   = 8'($urandom);
      cmd.len  = 3'($urandom_range(0, 7));
      cmd.side = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 25)      status = 8'h00;
      else if (r < 40) status = ACK_OP;
      else             status = 8'($urandom);
      push_beat(req, cmd, status);
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    logic [7:0] plan [5][4];
    int         weights [5][3];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values.
    push_beat(REQ_RESP, '0, 8'h33);          // response on empty queue: ack, side 0
    push_beat(REQ_ACK, '0, 8'h00);
    push_beat(REQ_TICK, '0, 8'h00);          // first tick: all four polls queued
    enq_beat(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 1'b1);
    enq_beat(8'h00, 8'hAA, 8'hAA, 8'hAA, 3'd6, 1'b0);   // opcode zero stays empty
    enq_beat(8'hFF, 8'h55, 8'h66, 8'h77, 3'd5, 1'b1);   // coalesces onto 0xFF/right
    enq_beat(ADDR_POLL_OP, 8'h12, 8'h00, 8'h00, 3'd0, 1'b0);  // overwrites a poll
    push_beat(REQ_TICK, '0, 8'h00);          // head goes out
    push_beat(REQ_ACK, '0, 8'h00);           // timer stops, send stays outstanding
    push_beat(REQ_TICK, '0, 8'h00);
    push_beat(REQ_RESP, '0, ACK_OP);         // behaves as a peer ack
    push_beat(REQ_RESP, '0, 8'h00);          // dequeue without ack
    push_beat(REQ_TICK, '0, 8'h00);
    push_beat(REQ_RESP, '1, 8'hFF);          // ack returned
    for (int k = 0; k < 10; k++)             // fills the queue, the tail is lost
      enq_beat(8'h40 + 8'(k), 8'(k), 8'hFF - 8'(k), 8'h0F, 3'(k), 1'b0);
    push_beat(REQ_TICK, '1, 8'hFF);
    settle();

    // Register settings: low extremes, high extremes, zero cases, random,
    // and a slow-response run that saturates the retry count.
    plan[0] = '{8'd1,   8'd0,   8'd1,   8'd1};
    plan[1] = '{8'd255, 8'd15,  8'd255, 8'd255};
    plan[2] = '{8'd0,   8'hF2,  8'd0,   8'd3};
    plan[3] = '{8'($urandom_range(1, 255)), 8'($urandom_range(0, 15)),
                8'($urandom_range(1, 40)),  8'($urandom_range(1, 40))};
    plan[4] = '{8'd2,   8'd15,  8'd9,   8'd0};
    weights[0] = '{35, 35, 20};
    weights[1] = '{40, 30, 15};
    weights[2] = '{35, 30, 20};
    weights[3] = '{35, 30, 20};
    weights[4] = '{60, 30, 4};

    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_RETRY_TICKS,  plan[p][0]);
      write_reg(CFG_MAX_RETRIES,  plan[p][1]);
      write_reg(CFG_ADDR_PERIOD,  plan[p][2]);
      write_reg(CFG_COUNT_PERIOD, plan[p][3]);
      cfg_valid <= 1'b0;
      @(posedge clk);
      random_run(RAND_ITEMS, weights[p][0], weights[p][1], weights[p][2]);
      settle();
    end

    if (link_book.mismatches == 0 && link_book.msg_expected.size() == 0)
      $display("coalescing_command_queue_retry_tb: done, clean");
    else
      $display("coalescing_command_queue_retry_tb: done, errors");
    $finish;
  end

endmodule
